[hw/rtl/vaft_pkg.sv]
// ----------------------------------------------------------------------------
// vaft_pkg - shared definitions for the vector angle unit
// Widths, stage map, arctangent table and pipeline word types.
// ----------------------------------------------------------------------------
package vaft_pkg;

   // Field widths and CORDIC length
   localparam int COORD_WIDTH   = 24;
   localparam int ANGLE_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int TOL_WIDTH     = 11;

   // Snap tolerance after reset
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);

   // Datapath widths
   localparam int PROD_W     = 2 * COORD_WIDTH;      // one product
   localparam int SUM_W      = PROD_W + 1;           // dot / cross, signed
   localparam int MAG_W      = PROD_W;               // magnitude of dot / cross
   localparam int NORM_LIMIT = 40;                   // CORDIC input below 2^40
   localparam int EXT_W      = MAG_W + NORM_LIMIT;   // room for the shifter
   localparam int SHIFT_W    = $clog2(MAG_W + 1);
   localparam int CX_W       = NORM_LIMIT + 3;       // x/y with CORDIC growth
   localparam int Z_W        = 34;                   // angle accumulator, 2^32 per turn

   localparam logic signed [Z_W-1:0] TURN_QUARTER = Z_W'(64'd1 << 30);
   localparam logic [32:0] TURN_HALF_33  = 33'd1 << 31;
   localparam logic [32:0] TURN_FULL_33  = 33'd1 << 32;
   localparam logic [32:0] ROUND_BIT     = 33'd1 << (31 - ANGLE_WIDTH);
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_HALF = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);

   // Stage map
   localparam int ST_PROD = 0;
   localparam int ST_SUM  = 1;
   localparam int ST_NORM = 2;
   localparam int ST_QUAD = ST_NORM + CORDIC_STAGES + 1;
   localparam int ST_OUT  = ST_QUAD + 1;
   localparam int N_STG   = ST_OUT + 1;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURN32 [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [ANGLE_WIDTH-1:0]        angle_type;
   typedef logic [TOL_WIDTH-1:0]          tol_type;

   // Products of the input word
   typedef struct packed {
      logic signed [PROD_W-1:0] rx_ox;
      logic signed [PROD_W-1:0] ry_oy;
      logic signed [PROD_W-1:0] rx_oy;
      logic signed [PROD_W-1:0] ry_ox;
      logic                     zero;
   } prod_type;

   // Dot and cross products
   typedef struct packed {
      logic signed [SUM_W-1:0] dot;
      logic signed [SUM_W-1:0] crs;
      logic                    zero;
   } sum_type;

   // CORDIC word
   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   dneg;
      logic                   cneg;
      logic                   zero;
   } cd_type;

   // Rounded full-turn angle, or final result
   typedef struct packed {
      angle_type angle;
      logic      zero;
   } res_type;

   // Right shift that brings a magnitude below 2^NORM_LIMIT
   function automatic logic [SHIFT_W-1:0] norm_shift(input logic [MAG_W-1:0] v);
      logic [SHIFT_W-1:0] s;
      s = '0;
      for (int i = NORM_LIMIT; i < MAG_W; i++) begin
         if (v[i]) s = SHIFT_W'(i - NORM_LIMIT + 1);
      end
      return s;
   endfunction

endpackage

[hw/rtl/vaft_req_if.sv]
// ----------------------------------------------------------------------------
// vaft_req_if - request channel of the vector angle unit
// Valid/ready channel carrying the two input vectors.
// ----------------------------------------------------------------------------
interface vaft_req_if;
   import vaft_pkg::*;

   logic      valid;
   logic      ready;
   coord_type ref_x;
   coord_type ref_y;
   coord_type other_x;
   coord_type other_y;

   modport source (output valid, output ref_x, output ref_y,
                   output other_x, output other_y, input ready);
   modport sink   (input valid, input ref_x, input ref_y,
                   input other_x, input other_y, output ready);
endinterface

[hw/rtl/vaft_rsp_if.sv]
// ----------------------------------------------------------------------------
// vaft_rsp_if - response channel of the vector angle unit
// Valid/ready channel carrying the angle and the zero-vector flag.
// ----------------------------------------------------------------------------
interface vaft_rsp_if;
   import vaft_pkg::*;

   logic      valid;
   logic      ready;
   angle_type angle;
   logic      zero_vector;

   modport source (output valid, output angle, output zero_vector, input ready);
   modport sink   (input valid, input angle, input zero_vector, output ready);
endinterface

[hw/rtl/vector_angle_full_turn_unit.sv]
// ----------------------------------------------------------------------------
// vector_angle_full_turn_unit - counter-clockwise angle between two vectors
// Dot/cross products, normalisation, vectoring CORDIC, quadrant fix-up, snap.
// ----------------------------------------------------------------------------
// The unit takes one word per cycle while the response side is not
// stalled, and returns one result word for each, in order. The pipeline
// has one stage for the four products, one for the dot/cross sums, one
// for the magnitude and normalising shift, one per CORDIC iteration, one
// for the quadrant fix-up and rounding, and the output register that
// applies the snap. Each stage holds its word under back-pressure and
// empty stages still take new words, so a stalled result does not block
// input while bubbles remain. The snap tolerance (reset value 1) is
// written through csr_we/csr_wdata; the user must write it only while
// the unit is idle, as the unit itself does not enforce this.
module vector_angle_full_turn_unit (
   input  logic              clock,
   input  logic              reset,
   vaft_req_if.sink          req_chan,
   vaft_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  vaft_pkg::tol_type csr_wdata
);
   import vaft_pkg::*;

   // One CORDIC rotation, direction from the sign of y
   function automatic cd_type cordic_step(input cd_type c, input int unsigned i);
      cd_type                 r;
      logic signed [CX_W-1:0] xs;
      logic signed [CX_W-1:0] ys;
      logic signed [Z_W-1:0]  at;
      xs = c.x >>> i;
      ys = c.y >>> i;
      at = Z_W'($signed({1'b0, ATAN_TURN32[i]}));
      r  = c;
      if (!c.y[CX_W-1]) begin
         r.x = c.x + ys;
         r.y = c.y - xs;
         r.z = c.z + at;
      end else begin
         r.x = c.x - ys;
         r.y = c.y + xs;
         r.z = c.z - at;
      end
      return r;
   endfunction

   tol_type           snap_tol_ff;
   logic [N_STG-1:0]  v_ff;
   logic [N_STG-1:0]  v_in;
   logic [N_STG:0]    en;

   prod_type prod_ff, prod_in;
   sum_type  sum_ff, sum_in;
   cd_type   cd_ff [CORDIC_STAGES+1];
   cd_type   cd_in [CORDIC_STAGES+1];
   res_type  quad_ff, quad_in;
   res_type  out_ff, out_in;

   // Stage enables: a stage loads when empty or when its successor moves
   always_comb begin
      en[N_STG] = rsp_chan.ready;
      for (int k = N_STG - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = req_chan.valid;
      for (int k = 1; k < N_STG; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   assign req_chan.ready = en[ST_PROD];

   // Control: valid bits and the tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff        <= '0;
         snap_tol_ff <= TOL_RESET;
      end else begin
         if (csr_we) snap_tol_ff <= csr_wdata;
         for (int k = 0; k < N_STG; k++) begin
            if (en[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   // Products and zero-vector test
   always_comb begin
      prod_in.rx_ox = PROD_W'(req_chan.ref_x) * PROD_W'(req_chan.other_x);
      prod_in.ry_oy = PROD_W'(req_chan.ref_y) * PROD_W'(req_chan.other_y);
      prod_in.rx_oy = PROD_W'(req_chan.ref_x) * PROD_W'(req_chan.other_y);
      prod_in.ry_ox = PROD_W'(req_chan.ref_y) * PROD_W'(req_chan.other_x);
      prod_in.zero  = (req_chan.ref_x == '0 && req_chan.ref_y == '0) ||
                      (req_chan.other_x == '0 && req_chan.other_y == '0);
   end

   // Dot and cross
   always_comb begin
      sum_in.dot  = SUM_W'(prod_ff.rx_ox) + SUM_W'(prod_ff.ry_oy);
      sum_in.crs  = SUM_W'(prod_ff.rx_oy) - SUM_W'(prod_ff.ry_ox);
      sum_in.zero = prod_ff.zero;
   end

   // Magnitudes, common normalising shift
   always_comb begin
      logic [SUM_W-1:0]   dabs;
      logic [SUM_W-1:0]   cabs;
      logic [MAG_W-1:0]   dmag;
      logic [MAG_W-1:0]   cmag;
      logic [SHIFT_W-1:0] sh;
      logic [EXT_W-1:0]   dsh;
      logic [EXT_W-1:0]   csh;
      dabs = sum_ff.dot[SUM_W-1] ? SUM_W'(-sum_ff.dot) : SUM_W'(sum_ff.dot);
      cabs = sum_ff.crs[SUM_W-1] ? SUM_W'(-sum_ff.crs) : SUM_W'(sum_ff.crs);
      dmag = dabs[MAG_W-1:0];
      cmag = cabs[MAG_W-1:0];
      sh   = norm_shift(dmag | cmag);
      dsh  = EXT_W'(dmag) >> sh;
      csh  = EXT_W'(cmag) >> sh;
      cd_in[0].x    = $signed({3'b000, dsh[NORM_LIMIT-1:0]});
      cd_in[0].y    = $signed({3'b000, csh[NORM_LIMIT-1:0]});
      cd_in[0].z    = '0;
      cd_in[0].dneg = sum_ff.dot[SUM_W-1];
      cd_in[0].cneg = sum_ff.crs[SUM_W-1];
      cd_in[0].zero = sum_ff.zero;
   end

   // CORDIC iterations, one per stage
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_iter
      assign cd_in[g+1] = cordic_step(cd_ff[g], g);
   end

   // Clamp, quadrant fix-up, round to the output width
   always_comb begin
      logic [30:0] zc;
      logic [32:0] a32;
      logic [32:0] rsum;
      if (cd_ff[CORDIC_STAGES].z[Z_W-1]) begin
         zc = '0;
      end else if (cd_ff[CORDIC_STAGES].z > TURN_QUARTER) begin
         zc = 31'(TURN_QUARTER);
      end else begin
         zc = cd_ff[CORDIC_STAGES].z[30:0];
      end
      case ({cd_ff[CORDIC_STAGES].dneg, cd_ff[CORDIC_STAGES].cneg})
         2'b00:   a32 = 33'(zc);
         2'b10:   a32 = TURN_HALF_33 - 33'(zc);
         2'b11:   a32 = TURN_HALF_33 + 33'(zc);
         default: a32 = TURN_FULL_33 - 33'(zc);
      endcase
      rsum          = a32 + ROUND_BIT;
      quad_in.angle = rsum[31 -: ANGLE_WIDTH];
      quad_in.zero  = cd_ff[CORDIC_STAGES].zero;
   end

   // Snap to zero or half turn; zero wins, zero vector overrides
   always_comb begin
      angle_type d0, e0, dh, eh, dist0, disth;
      d0    = quad_ff.angle;
      e0    = angle_type'(-quad_ff.angle);
      dh    = quad_ff.angle - ANGLE_HALF;
      eh    = ANGLE_HALF - quad_ff.angle;
      dist0 = (d0 < e0) ? d0 : e0;
      disth = (dh < eh) ? dh : eh;
      out_in.zero = quad_ff.zero;
      if (quad_ff.zero) begin
         out_in.angle = '0;
      end else if (32'(dist0) <= 32'(snap_tol_ff)) begin
         out_in.angle = '0;
      end else if (32'(disth) <= 32'(snap_tol_ff)) begin
         out_in.angle = ANGLE_HALF;
      end else begin
         out_in.angle = quad_ff.angle;
      end
   end

   // Pipeline data registers
   always_ff @(posedge clock) begin
      if (en[ST_PROD]) prod_ff <= prod_in;
      if (en[ST_SUM])  sum_ff  <= sum_in;
      for (int g = 0; g <= CORDIC_STAGES; g++) begin
         if (en[ST_NORM + g]) cd_ff[g] <= cd_in[g];
      end
      if (en[ST_QUAD]) quad_ff <= quad_in;
      if (en[ST_OUT])  out_ff  <= out_in;
   end

   assign rsp_chan.valid       = v_ff[ST_OUT];
   assign rsp_chan.angle       = out_ff.angle;
   assign rsp_chan.zero_vector = out_ff.zero;

   // Checks
   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.zero_vector |-> rsp_chan.angle == '0)
      else $error("zero vector result with non-zero angle");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v_ff[ST_PROD])
      else $error("accepted word missing from first stage");

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("input stalled with empty output stage");

endmodule
